// ----- hw/rtl/mce_pkg.sv -----
`timescale 1ns / 1ps

package mce_pkg;

    localparam int LBA_W = 32;
    localparam int HEADS_W = 9;
    localparam int SECT_W = 6;
    localparam int DIV_STAGES = LBA_W;
    localparam int IN_W = 72;
    localparam int OUT_W = 112;
    localparam int ADDR_W = 3;

    localparam logic [7:0] PTYPE_UNUSED = 8'h00;
    localparam logic [1:0] CYL_HI_SAT = 2'b11;
    localparam logic [7:0] CYL_LOW_SAT = 8'hff;
    localparam logic [8:0] HEAD_LIMIT = 9'd256;
    localparam logic [6:0] SECT_LIMIT = 7'd64;
    localparam logic [LBA_W-1:0] CYL_LIMIT = 32'd1024;

    localparam logic HEADS_REG_SEL = 1'b0;
    localparam logic SECT_REG_SEL = 1'b1;

    // Pipeline control shared by the lanes
    typedef struct packed {
        logic en;
    } pipe_ctrl_t;

    // Packed CHS triple: head, sector byte, cylinder low
    typedef struct packed {
        logic [7:0] cyl_low;
        logic [7:0] sect_byte;
        logic [7:0] head;
    } chs_t;

    // Build the CHS bytes from the divider results
    function automatic chs_t pack_chs(
        input logic [HEADS_W-1:0] heads,
        input logic [SECT_W-1:0] sects,
        input logic [SECT_W-1:0] sect_rem,
        input logic [HEADS_W-1:0] head,
        input logic [LBA_W-1:0] cyl
    );
        chs_t res;
        logic [6:0] sec;
        logic [HEADS_W-1:0] hm1;
        sec = {1'b0, sect_rem} + 7'd1;
        hm1 = heads - {{(HEADS_W-1){1'b0}}, 1'b1};
        if (heads == '0 || sects == '0) begin
            res = '0;
        end else if (head < HEAD_LIMIT && sec < SECT_LIMIT && cyl < CYL_LIMIT) begin
            res.head = head[7:0];
            res.sect_byte = {cyl[9:8], sec[5:0]};
            res.cyl_low = cyl[7:0];
        end else begin
            res.head = hm1[7:0];
            res.sect_byte = {CYL_HI_SAT, sects};
            res.cyl_low = CYL_LOW_SAT;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/mce_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage
module mce_div (
    input  logic                          aclk,
    input  mce_pkg::pipe_ctrl_t           ctrl,
    input  logic [mce_pkg::LBA_W-1:0]     dividend,
    input  logic [mce_pkg::HEADS_W-1:0]   divisor,
    output logic [mce_pkg::LBA_W-1:0]     quotient,
    output logic [mce_pkg::HEADS_W-1:0]   remainder
);

    logic [mce_pkg::HEADS_W-1:0] rem_reg [mce_pkg::DIV_STAGES];
    logic [mce_pkg::LBA_W-1:0]   num_reg [mce_pkg::DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < mce_pkg::DIV_STAGES; k++) begin : g_stage
            logic [mce_pkg::HEADS_W-1:0] rem_in;
            logic [mce_pkg::LBA_W-1:0]   num_in;
            logic [mce_pkg::HEADS_W:0]   trial;
            logic [mce_pkg::HEADS_W:0]   diff;
            logic                        ge;

            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign num_in = dividend;
            end else begin : g_next
                assign rem_in = rem_reg[k-1];
                assign num_in = num_reg[k-1];
            end

            // Shift in the next dividend bit and try the subtract
            always_comb begin
                trial = {rem_in, num_in[mce_pkg::LBA_W-1]};
                diff = trial - {1'b0, divisor};
                ge = (trial >= {1'b0, divisor});
            end

            always_ff @(posedge aclk) begin
                if (ctrl.en) begin
                    rem_reg[k] <= ge ? diff[mce_pkg::HEADS_W-1:0]
                                     : trial[mce_pkg::HEADS_W-1:0];
                    num_reg[k] <= {num_in[mce_pkg::LBA_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign quotient = num_reg[mce_pkg::DIV_STAGES-1];
    assign remainder = rem_reg[mce_pkg::DIV_STAGES-1];

endmodule

// ----- hw/rtl/mce_chs_lane.sv -----
`timescale 1ns / 1ps

// One sector number to sector remainder, head and cylinder
module mce_chs_lane (
    input  logic                          aclk,
    input  mce_pkg::pipe_ctrl_t           ctrl,
    input  logic [mce_pkg::LBA_W-1:0]     lba,
    input  logic [mce_pkg::HEADS_W-1:0]   heads,
    input  logic [mce_pkg::SECT_W-1:0]    sects,
    output logic [mce_pkg::SECT_W-1:0]    sect_rem,
    output logic [mce_pkg::HEADS_W-1:0]   head,
    output logic [mce_pkg::LBA_W-1:0]     cyl
);

    logic [mce_pkg::LBA_W-1:0]   track;
    logic [mce_pkg::HEADS_W-1:0] rem1;
    logic [mce_pkg::SECT_W-1:0]  srem_reg [mce_pkg::DIV_STAGES];

    // Track number and sector within track
    mce_div u_div_sect (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .dividend  (lba),
        .divisor   ({{(mce_pkg::HEADS_W-mce_pkg::SECT_W){1'b0}}, sects}),
        .quotient  (track),
        .remainder (rem1)
    );

    // Cylinder and head within cylinder
    mce_div u_div_head (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .dividend  (track),
        .divisor   (heads),
        .quotient  (cyl),
        .remainder (head)
    );

    // Hold the sector remainder alongside the second divider
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            srem_reg[0] <= rem1[mce_pkg::SECT_W-1:0];
            for (int i = 1; i < mce_pkg::DIV_STAGES; i++) begin
                srem_reg[i] <= srem_reg[i-1];
            end
        end
    end

    assign sect_rem = srem_reg[mce_pkg::DIV_STAGES-1];

endmodule

// ----- hw/rtl/mbr_entry_chs_encoder_core.sv -----
`timescale 1ns / 1ps

// MBR partition entry encoder. Each input transfer (start sector, size, type)
// yields one entry with start, count and packed begin/end CHS bytes for the
// geometry in the heads (addr 0) and sectors (addr 4) registers. The block
// takes one transfer per cycle when the result side is not stalled; each
// transfer lands in the input register, then passes two 32-stage
// bit-per-stage dividers in series (sector, then head) per CHS lane and the
// output register. A stall on the result side holds the whole
// pipeline. Change geometry only while no entries are in flight.
module mbr_entry_chs_encoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mce_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_lba[31:0], size_sectors[63:32], type_code[71:64]
    input  logic [mce_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // entry_start, entry_count, begin_head, begin_sector_byte,
    // begin_cylinder_low, end_head, end_sector_byte, end_cylinder_low
    output logic [mce_pkg::OUT_W-1:0]     m_tdata
);

    localparam int SIDE_STAGES = 2 * mce_pkg::DIV_STAGES;

    logic [mce_pkg::HEADS_W-1:0] heads_reg;
    logic [mce_pkg::SECT_W-1:0]  sects_reg;
    mce_pkg::pipe_ctrl_t         ctrl;

    logic                        a_valid_reg;
    logic [mce_pkg::LBA_W-1:0]   a_start_reg;
    logic [mce_pkg::LBA_W-1:0]   a_last_reg;
    logic [mce_pkg::LBA_W-1:0]   a_count_reg;
    logic                        a_empty_reg;

    logic                        v_reg     [SIDE_STAGES];
    logic [mce_pkg::LBA_W-1:0]   start_reg [SIDE_STAGES];
    logic [mce_pkg::LBA_W-1:0]   count_reg [SIDE_STAGES];
    logic                        empty_reg [SIDE_STAGES];

    logic [mce_pkg::SECT_W-1:0]  b_srem, e_srem;
    logic [mce_pkg::HEADS_W-1:0] b_head, e_head;
    logic [mce_pkg::LBA_W-1:0]   b_cyl, e_cyl;
    mce_pkg::chs_t               b_chs, e_chs;

    logic                        out_valid_reg;
    logic                        out_empty_reg;
    logic [mce_pkg::OUT_W-1:0]   out_data_reg;

    logic                        cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heads_reg <= 9'd255;
            sects_reg <= 6'd63;
        end else if (cfg_wr) begin
            if (paddr[2] == mce_pkg::HEADS_REG_SEL) begin
                heads_reg <= pwdata[mce_pkg::HEADS_W-1:0];
            end else begin
                sects_reg <= pwdata[mce_pkg::SECT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == mce_pkg::HEADS_REG_SEL) begin
            prdata = {{(32-mce_pkg::HEADS_W){1'b0}}, heads_reg};
        end else begin
            prdata = {{(32-mce_pkg::SECT_W){1'b0}}, sects_reg};
        end
    end

    // Advance the whole pipeline unless the result is held
    assign ctrl.en = !out_valid_reg || m_tready;
    assign s_tready = ctrl.en;

    // Input stage: end sector and empty check
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ctrl.en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            a_start_reg <= s_tdata[31:0];
            a_count_reg <= s_tdata[63:32];
            a_last_reg <= s_tdata[31:0] + s_tdata[63:32] - 32'd1;
            a_empty_reg <= (s_tdata[71:64] == mce_pkg::PTYPE_UNUSED)
                           && (s_tdata[63:32] == '0);
        end
    end

    mce_chs_lane u_begin (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .lba      (a_start_reg),
        .heads    (heads_reg),
        .sects    (sects_reg),
        .sect_rem (b_srem),
        .head     (b_head),
        .cyl      (b_cyl)
    );

    mce_chs_lane u_end (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .lba      (a_last_reg),
        .heads    (heads_reg),
        .sects    (sects_reg),
        .sect_rem (e_srem),
        .head     (e_head),
        .cyl      (e_cyl)
    );

    // Carry valid and entry fields beside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SIDE_STAGES; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (ctrl.en) begin
            v_reg[0] <= a_valid_reg;
            for (int i = 1; i < SIDE_STAGES; i++) begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            start_reg[0] <= a_empty_reg ? '0 : a_start_reg;
            count_reg[0] <= a_count_reg;
            empty_reg[0] <= a_empty_reg;
            for (int i = 1; i < SIDE_STAGES; i++) begin
                start_reg[i] <= start_reg[i-1];
                count_reg[i] <= count_reg[i-1];
                empty_reg[i] <= empty_reg[i-1];
            end
        end
    end

    // Pack CHS bytes into the output register
    assign b_chs = mce_pkg::pack_chs(heads_reg, sects_reg, b_srem, b_head, b_cyl);
    assign e_chs = mce_pkg::pack_chs(heads_reg, sects_reg, e_srem, e_head, e_cyl);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.en) begin
            out_valid_reg <= v_reg[SIDE_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            out_empty_reg <= empty_reg[SIDE_STAGES-1];
            if (empty_reg[SIDE_STAGES-1]) begin
                out_data_reg <= {48'd0, count_reg[SIDE_STAGES-1], 32'd0};
            end else begin
                out_data_reg <= {e_chs.cyl_low, e_chs.sect_byte, e_chs.head,
                                 b_chs.cyl_low, b_chs.sect_byte, b_chs.head,
                                 count_reg[SIDE_STAGES-1], start_reg[SIDE_STAGES-1]};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

`ifndef SYNTH
    // Empty entry carries no CHS bytes
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_empty_reg) |-> (out_data_reg[111:64] == '0))
        else $error("empty entry with nonzero CHS");

    // No geometry gives zero CHS bytes
    a_nogeom_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (heads_reg == '0 || sects_reg == '0))
        |-> (out_data_reg[111:64] == '0))
        else $error("CHS bytes without geometry");

    // With geometry, a nonempty entry has a sector number of at least one
    a_sector_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_empty_reg && heads_reg != '0 && sects_reg != '0)
        |-> (out_data_reg[77:72] != '0 && out_data_reg[101:96] != '0))
        else $error("CHS sector field is zero");
`endif

endmodule

// ----- tb/sv/mbr_entry_chs_encoder_core_test.sv -----
`timescale 1ns / 1ps

module mbr_entry_chs_encoder_core_test;

    // Result layout, lowest field in the lowest bits
    typedef struct packed {
        logic [7:0]  end_cyl;
        logic [7:0]  end_sect;
        logic [7:0]  end_head;
        logic [7:0]  begin_cyl;
        logic [7:0]  begin_sect;
        logic [7:0]  begin_head;
        logic [31:0] count;
        logic [31:0] start;
    } mbr_entry_t;

    localparam logic [mce_pkg::ADDR_W-1:0] HEADS_ADDR = 3'd0;
    localparam logic [mce_pkg::ADDR_W-1:0] SECTS_ADDR = 3'd4;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [mce_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // start_lba[31:0], size_sectors[63:32], type_code[71:64]
    logic [mce_pkg::IN_W-1:0]   s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // entry_start, entry_count, begin_head, begin_sector_byte,
    // begin_cylinder_low, end_head, end_sector_byte, end_cylinder_low
    logic [mce_pkg::OUT_W-1:0]  m_tdata;

    mbr_entry_chs_encoder_core i_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Geometry copy, idle percentages and checking state
    logic [8:0]  geo_heads = 9'd255;
    logic [5:0]  geo_sects = 6'd63;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          error_count = 0;
    mbr_entry_t  pending_entries[$];

    // Packed CHS of one sector as {cyl_low, sect_byte, head}
    function automatic logic [23:0] chs_of(logic [31:0] lba);
        logic [31:0] h;
        logic [31:0] s;
        logic [31:0] sec;
        logic [31:0] head;
        logic [31:0] cyl;
        logic [7:0]  hm1;
        h = {23'd0, geo_heads};
        s = {26'd0, geo_sects};
        if (h == 0 || s == 0) return 24'd0;
        sec = 1 + lba % s;
        head = (lba / s) % h;
        cyl = lba / (h * s);
        if (head < 256 && sec < 64 && cyl < 1024)
            return {cyl[7:0], cyl[9:8], sec[5:0], head[7:0]};
        hm1 = 8'(h - 1);
        return {8'hff, 2'b11, geo_sects, hm1};
    endfunction

    function automatic mbr_entry_t encode_entry(logic [31:0] start, logic [31:0] size,
                                                logic [7:0] ptype);
        mbr_entry_t e;
        logic [23:0] b;
        logic [23:0] f;
        e = '0;
        e.count = size;
        if (!(ptype == mce_pkg::PTYPE_UNUSED && size == 0)) begin
            e.start = start;
            b = chs_of(start);
            f = chs_of(start + size - 32'd1);
            {e.begin_cyl, e.begin_sect, e.begin_head} = b;
            {e.end_cyl, e.end_sect, e.end_head} = f;
        end
        return e;
    endfunction

    // Stall the result side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Compare each result transfer with the oldest pending entry
    always @(posedge aclk) begin
        mbr_entry_t want;
        mbr_entry_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_entries.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_entries.pop_front();
                check_field("entry_start", want.start, got.start);
                check_field("entry_count", want.count, got.count);
                check_field("begin_head", 32'(want.begin_head), 32'(got.begin_head));
                check_field("begin_sector_byte", 32'(want.begin_sect),
                            32'(got.begin_sect));
                check_field("begin_cylinder_low", 32'(want.begin_cyl),
                            32'(got.begin_cyl));
                check_field("end_head", 32'(want.end_head), 32'(got.end_head));
                check_field("end_sector_byte", 32'(want.end_sect), 32'(got.end_sect));
                check_field("end_cylinder_low", 32'(want.end_cyl), 32'(got.end_cyl));
            end
        end
    end

    // Send one partition; valid stays high into the next send when no gap falls
    task automatic send_entry(logic [31:0] start, logic [31:0] size, logic [7:0] ptype);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ptype, size, start};
        do @(posedge aclk); while (!s_tready);
        pending_entries.push_back(encode_entry(start, size, ptype));
    endtask

    // Hold the input until every pending entry is out, then let the pipe settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [mce_pkg::ADDR_W-1:0] addr, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == HEADS_ADDR) geo_heads = value[8:0];
        else geo_sects = value[5:0];
    endtask

    task automatic set_geometry(logic [8:0] heads, logic [5:0] sects);
        wait_drain();
        write_reg(HEADS_ADDR, {23'd0, heads});
        write_reg(SECTS_ADDR, {26'd0, sects});
    endtask

    // Corner partitions under the reset geometry
    task automatic test_corner_entries();
        send_entry(32'd0, 32'd0, mce_pkg::PTYPE_UNUSED);
        send_entry(32'd5000, 32'd0, 8'h83);
        send_entry(32'd0, 32'd0, 8'h07);
        send_entry(32'd0, 32'd1, 8'h0c);
        send_entry(32'hffff_ffff, 32'd1, 8'hff);
        send_entry(32'd0, 32'hffff_ffff, 8'h83);
        send_entry(32'd63, 32'd16_450_497, 8'h83);
        send_entry(32'd16_450_559, 32'd2, 8'h05);
        send_entry(32'd123, 32'd456, mce_pkg::PTYPE_UNUSED);
        send_entry(32'hffff_ffff, 32'hffff_ffff, 8'h80);
    endtask

    // Zero, saturating and widest geometries
    task automatic test_geometry_extremes();
        set_geometry(9'd0, 6'd63);
        send_entry(32'd100, 32'd100, 8'h83);
        set_geometry(9'd255, 6'd0);
        send_entry(32'd100, 32'd100, 8'h83);
        set_geometry(9'd256, 6'd63);
        send_entry(32'd0, 32'd16_515_072, 8'h83);
        send_entry(32'd16_515_071, 32'd1, 8'h83);
        set_geometry(9'd1, 6'd1);
        send_entry(32'd1023, 32'd2, 8'h0b);
        set_geometry(9'd511, 6'd63);
        send_entry(32'd16_000, 32'd20, 8'h83);
        send_entry(32'd200, 32'd20, 8'h83);
        set_geometry(9'd16, 6'd32);
        send_entry(32'd524_287, 32'd1, 8'h83);
        send_entry(32'd524_288, 32'd1, 8'h83);
    endtask

    task automatic send_random_entry();
        logic [31:0] start;
        logic [31:0] size;
        logic [7:0]  ptype;
        case ($urandom_range(3))
            0: start = $urandom;
            1: start = $urandom_range(1024);
            default: start = $urandom_range(20_000_000);
        endcase
        case ($urandom_range(4))
            0: size = $urandom;
            1: size = 32'd0;
            default: size = $urandom_range(5_000_000);
        endcase
        ptype = ($urandom_range(4) == 0) ? mce_pkg::PTYPE_UNUSED : 8'($urandom);
        send_entry(start, size, ptype);
    endtask

    // Random partitions under random geometry, one idle mode per phase
    task automatic test_random_phase(int send_pct, int recv_pct, bit pause_mid);
        set_geometry(($urandom_range(5) == 0) ? 9'($urandom) : 9'($urandom_range(256)),
                     6'($urandom));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < 145; i++) begin
            if (i % 50 == 0 && i != 0)
                set_geometry(9'($urandom_range(1, 256)), 6'($urandom_range(1, 63)));
            if (pause_mid && i == 70) begin
                s_tvalid <= 1'b0;
                while (pending_entries.size() != 0) @(posedge aclk);
            end
            send_random_entry();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 26;
        recv_idle_pct = 70;
        test_corner_entries();
        test_geometry_extremes();
        test_random_phase(26, 70, 1'b1);
        test_random_phase(70, 26, 1'b0);
        test_random_phase(0, 0, 1'b0);
        wait_drain();
        if (error_count == 0)
            $display("mbr_entry_chs_encoder_core_test OK");
        else
            $display("mbr_entry_chs_encoder_core_test NOT OK");
        $finish;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("mbr_entry_chs_encoder_core_test NOT OK");
        $finish;
    end

endmodule
